>>> rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;
  localparam int DEF_SLOTS = 64;
  localparam int DEF_KEY_BYTES = 8;
  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] FNV_MULT = 64'd1099511628211;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;
endpackage
`default_nettype wire

>>> rtl/lpht_ram.sv
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/lpht_hash.sv
`default_nettype none
module lpht_hash import lpht_pkg::*; #(
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [KEY_BYTES*8-1:0]      key,
  input  wire logic [3:0]                  len,
  output logic                             done,
  output logic      [63:0]                 hash
);
  // one xor-multiply round per key byte, done in two phases; multiply split into two 32-bit halves
  localparam int KW = KEY_BYTES * 8;
  logic [3:0]    idx;
  logic          busy;
  logic          phase;
  logic [63:0]   x;
  logic [63:0]   lo_prod;
  logic [KW-1:0] shifted;
  logic [KW-1:0] r_key;
  logic [3:0]    r_len;

  // key and length are held for the whole hash, the input ports move on
  assign shifted = r_key >> {idx, 3'b000};
  assign x = hash ^ {56'd0, shifted[7:0]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      hash <= FNV_BASIS;
      idx <= '0;
      r_key <= key;
      r_len <= len;
      phase <= 1'b0;
      busy <= 1'b1;
      if (len == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (busy) begin
      if (!phase) begin
        hash <= x;
        lo_prod <= x * {32'd0, FNV_MULT[31:0]};
        phase <= 1'b1;
      end else begin
        // FNV_MULT upper half is 0x100: high product is a shift
        hash <= lo_prod + {hash[31:0] << 8, 32'd0};
        phase <= 1'b0;
        idx <= idx + 4'd1;
        if (idx + 4'd1 == r_len) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_table_core.sv
// Linear-probing hash table core.
// Input channel (in_valid/in_ready) takes one request item: kind, key_bytes,
// key_length, value_in. Output channel (out_valid/out_ready) returns one result
// item per request: status, value_out, slot_index, entry_count.
// One request at a time. A request first runs the FNV-1a hash, one round per
// key byte (up to KEY_BYTES), then probes the slot memories one slot at a time
// (read, then decide/write), from 1 up to SLOTS probes.
// The result sits in an output register and the core goes idle at once, so the
// next request is accepted while the result waits; a stalled receiver holds
// the next request in its decide step until the register is free.
// After reset a clearing pass writes every slot mark to empty, one slot a
// cycle, during which in_ready stays low.
`default_nettype none
module linear_probe_hash_table_core import lpht_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               kind,
  input  wire logic [KEY_BYTES*8-1:0]   key_bytes,
  input  wire logic [3:0]               key_length,
  input  wire logic [63:0]              value_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [1:0]               status,
  output logic      [63:0]              value_out,
  output logic      [5:0]               slot_index,
  output logic      [6:0]               entry_count
);
  localparam int AW = $clog2(SLOTS);
  localparam int KW = KEY_BYTES * 8;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t          state;
  logic [1:0]      r_kind;
  logic [KW-1:0]   r_key;
  logic [3:0]      r_len;
  logic [63:0]     r_value;
  logic [AW-1:0]   addr;
  logic [AW:0]     probes;
  logic            have_free;
  logic [AW-1:0]   free_slot;
  logic [CW-1:0]   live_count;
  logic [AW-1:0]   clr_addr;

  logic            hash_done;
  logic [63:0]     hash;
  logic [3:0]      len_sat;
  logic [KW-1:0]   key_masked;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [1:0]      w_mark;
  logic            wr_kv;
  logic            wr_val;
  logic [1:0]      rd_mark;
  logic [KW-1:0]   rd_key;
  logic [3:0]      rd_len;
  logic [63:0]     rd_value;

  always_comb begin
    len_sat = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
    key_masked = key_bytes;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (4'(b) >= len_sat) begin
        key_masked[b*8 +: 8] = 8'd0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(in_valid && in_ready),
    .key  (key_masked),
    .len  (len_sat),
    .done (hash_done),
    .hash (hash)
  );

  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
    .clk(clk), .we(we), .waddr(waddr), .wdata(w_mark), .raddr(addr), .rdata(rd_mark)
  );
  lpht_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(wr_kv), .waddr(waddr), .wdata(r_key), .raddr(addr), .rdata(rd_key)
  );
  lpht_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_len (
    .clk(clk), .we(wr_kv), .waddr(waddr), .wdata(r_len), .raddr(addr), .rdata(rd_len)
  );
  lpht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(wr_val), .waddr(waddr), .wdata(r_value), .raddr(addr),
    .rdata(rd_value)
  );

  logic match;
  assign match = (rd_mark == MARK_LIVE) && (rd_len == r_len) && (rd_key == r_key);

  logic out_free;
  logic last_probe;
  logic ins_place;
  logic eval_end;
  logic res_load;

  assign out_free = !out_valid || out_ready;
  assign last_probe = (probes == (AW+1)'(SLOTS - 1));
  assign ins_place = (rd_mark == MARK_EMPTY || last_probe) &&
                     (have_free || rd_mark == MARK_EMPTY || rd_mark == MARK_DELETED);

  // decide step ends the request here
  always_comb begin
    eval_end = 1'b1;
    if (r_kind == KIND_INSERT) begin
      eval_end = match || ins_place || last_probe;
    end else if (r_kind == KIND_LOOKUP || r_kind == KIND_REMOVE) begin
      eval_end = match || rd_mark == MARK_EMPTY || last_probe;
    end
  end

  assign res_load = (state == S_EVAL) && out_free && eval_end;

  // write port decode from the clearing pass and the decide step
  always_comb begin
    we = 1'b0;
    wr_kv = 1'b0;
    wr_val = 1'b0;
    waddr = addr;
    w_mark = MARK_LIVE;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_addr;
      w_mark = MARK_EMPTY;
    end else if (state == S_EVAL && out_free) begin
      if (r_kind == KIND_INSERT) begin
        if (match) begin
          wr_val = 1'b1;
        end else if (ins_place) begin
          we = 1'b1;
          wr_kv = 1'b1;
          wr_val = 1'b1;
          waddr = have_free ? free_slot : addr;
        end
      end else if (r_kind == KIND_REMOVE && match) begin
        we = 1'b1;
        w_mark = MARK_DELETED;
      end
    end
  end

  task automatic finish(input logic [1:0] st, input logic [63:0] v,
                        input logic [AW-1:0] s, input logic [CW-1:0] c);
    status <= st;
    value_out <= v;
    slot_index <= 6'(s);
    entry_count <= 7'(c);
    state <= S_IDLE;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      live_count <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load || (out_valid && !out_ready);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            r_kind <= kind;
            r_key <= key_masked;
            r_len <= len_sat;
            r_value <= value_in;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            addr <= hash[AW-1:0];
            probes <= '0;
            have_free <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!out_free) begin
            state <= S_EVAL;
          end else if (r_kind == KIND_INSERT) begin
            if (match) begin
              finish(ST_DONE, 64'd0, addr, live_count);
            end else if (we) begin
              live_count <= live_count + 1'b1;
              finish(ST_DONE, 64'd0, waddr, live_count + 1'b1);
            end else if (last_probe) begin
              finish(ST_FULL, 64'd0, '0, live_count);
            end else begin
              if (rd_mark == MARK_DELETED && !have_free) begin
                have_free <= 1'b1;
                free_slot <= addr;
              end
              probes <= probes + 1'b1;
              addr <= addr + 1'b1;
              state <= S_READ;
            end
          end else if (r_kind == KIND_LOOKUP || r_kind == KIND_REMOVE) begin
            if (match) begin
              if (r_kind == KIND_LOOKUP) begin
                finish(ST_DONE, rd_value, addr, live_count);
              end else begin
                live_count <= live_count - 1'b1;
                finish(ST_DONE, 64'd0, addr, live_count - 1'b1);
              end
            end else if (rd_mark == MARK_EMPTY || last_probe) begin
              finish(ST_NOT_FOUND, 64'd0, '0, live_count);
            end else begin
              probes <= probes + 1'b1;
              addr <= addr + 1'b1;
              state <= S_READ;
            end
          end else begin
            // unused kind touches nothing
            finish(ST_NOT_FOUND, 64'd0, '0, live_count);
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/lpht_checker.sv
`default_nettype none
module lpht_checker import lpht_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [63:0] value_out,
  input wire logic [5:0] slot_index,
  input wire logic [6:0] entry_count
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("item accepted while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out) &&
                               $stable(slot_index) && $stable(entry_count))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> value_out == 64'd0 && slot_index == 6'd0)
    else $error("failed request with nonzero fields");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 7'd64) else $error("entry count out of range");
endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .value_out(value_out), .slot_index(slot_index), .entry_count(entry_count)
);
`default_nettype wire
